// ----- hdl/brctc_pkg.sv -----
// ----------------------------------------------------------------------------
// Block read cache tag controller package
// Widths, sizes and the command/status types shared by the controller and
// the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brctc_pkg;

  localparam int Ways        = 4;
  localparam int WayW        = $clog2(Ways);
  localparam int BlockBytes  = 32 * 1024;
  localparam int OffW        = $clog2(BlockBytes);
  localparam int PosW        = 48;
  localparam int TagW        = PosW - OffW;
  localparam int LenW        = 19;
  localparam int SegW        = 16;
  localparam int StampW      = 32;
  localparam int MaxReqBytes = 262144;
  localparam int MaxResults  = 9;
  localparam int CntW        = $clog2(MaxResults);

  // Command modes carried on mode_i.
  localparam logic ModeRead       = 1'b0;
  localparam logic ModeInvalidate = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch a read request
    logic inval;  // clear every valid bit
    logic check;  // range check and clip of the latched request
    logic seg;    // look up and report one segment
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;    // latched request is rejected
    logic last;   // segment being reported is the final one
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/brctc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Block read cache tag controller: sequencer
// Accepts commands, steps through the range check and, unless it rejects the
// request, one segment per cycle until the datapath flags the final segment.
// ----------------------------------------------------------------------------
`default_nettype none

module brctc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire logic                  mode_i,
  input  wire brctc_pkg::dp_status_t status_i,
  output logic                       busy,
  output brctc_pkg::ctrl_cmd_t       cmd_o
);
  import brctc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StSeg   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       idle;

  assign idle = (state_q == StIdle);
  assign busy = !idle;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = idle && start && (mode_i == ModeRead);
    cmd_o.inval = idle && start && (mode_i == ModeInvalidate);
    cmd_o.check = (state_q == StCheck);
    cmd_o.seg   = (state_q == StSeg);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.load) state_d = StCheck;
      end
      StCheck: begin
        state_d = status_i.err ? StIdle : StSeg;
      end
      StSeg: begin
        if (status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/brctc_dp.sv -----
// ----------------------------------------------------------------------------
// Block read cache tag controller: datapath
// Holds the file length, the way table and the request being split, and
// registers each result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module brctc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brctc_pkg::ctrl_cmd_t          cmd_i,
  output brctc_pkg::dp_status_t              status_o,
  input  wire logic                          file_length_we_i,
  input  wire logic [brctc_pkg::PosW-1:0]    file_length_i,
  input  wire logic [brctc_pkg::PosW-1:0]    position_i,
  input  wire logic [brctc_pkg::LenW-1:0]    length_i,
  output logic                               valid_o,
  output logic [brctc_pkg::WayW-1:0]         way_o,
  output logic [brctc_pkg::OffW-1:0]         block_offset_o,
  output logic [brctc_pkg::SegW-1:0]         segment_bytes_o,
  output logic                               hit_o,
  output logic                               fetch_needed_o,
  output logic [brctc_pkg::PosW-1:0]         fetch_address_o,
  output logic [brctc_pkg::SegW-1:0]         fetch_bytes_o,
  output logic                               error_o,
  output logic [brctc_pkg::LenW-1:0]         total_bytes_o,
  output logic                               last_o
);
  import brctc_pkg::*;

  logic [PosW-1:0]   file_len_q;
  logic [PosW-1:0]   pos_q;
  logic [LenW-1:0]   rem_q;
  logic [LenW-1:0]   total_q;
  logic [CntW-1:0]   cnt_q;

  logic              way_valid_q [Ways];
  logic [TagW-1:0]   way_tag_q   [Ways];
  logic [StampW-1:0] way_stamp_q [Ways];
  logic [StampW-1:0] next_stamp_q;

  logic              valid_q;
  logic [WayW-1:0]   way_q;
  logic [OffW-1:0]   off_q;
  logic [SegW-1:0]   seg_q;
  logic              hit_q;
  logic [PosW-1:0]   faddr_q;
  logic [SegW-1:0]   fbytes_q;
  logic              err_q;
  logic [LenW-1:0]   total_out_q;
  logic              last_q;

  // Request intake, range check and clip.
  logic [LenW-1:0]   len_sat;
  logic [PosW:0]     end_sum;
  logic              err;
  logic              clip;

  assign len_sat = (length_i > LenW'(MaxReqBytes)) ? LenW'(MaxReqBytes) : length_i;
  assign end_sum = {1'b0, pos_q} + (PosW+1)'(rem_q);
  assign err     = (rem_q == '0) || (pos_q >= file_len_q);
  assign clip    = (end_sum >= {1'b0, file_len_q});

  // Segment split.
  logic [TagW-1:0]   tag;
  logic [OffW-1:0]   off;
  logic [SegW-1:0]   room;
  logic [SegW-1:0]   seg;
  logic [LenW-1:0]   rem_next;
  logic              last;

  assign tag      = pos_q[PosW-1:OffW];
  assign off      = pos_q[OffW-1:0];
  assign room     = SegW'(BlockBytes) - SegW'(off);
  assign seg      = (rem_q <= LenW'(room)) ? rem_q[SegW-1:0] : room;
  assign rem_next = rem_q - LenW'(seg);
  assign last     = (rem_next == '0) || (cnt_q == CntW'(MaxResults - 1));

  assign status_o.err  = err;
  assign status_o.last = last;

  // Tag lookup and victim choice: first invalid way, else the oldest stamp
  // with the lowest way winning ties.
  logic              hit;
  logic [WayW-1:0]   hit_way;
  logic              any_free;
  logic [WayW-1:0]   free_way;
  logic [WayW-1:0]   old_way;
  logic [StampW-1:0] old_stamp;
  logic [WayW-1:0]   way_sel;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    any_free  = 1'b0;
    free_way  = '0;
    old_way   = '0;
    old_stamp = way_stamp_q[0];
    for (int w = Ways - 1; w >= 0; w--) begin
      if (way_valid_q[w] && (way_tag_q[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
      if (!way_valid_q[w]) begin
        any_free = 1'b1;
        free_way = WayW'(w);
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (way_stamp_q[w] < old_stamp) begin
        old_stamp = way_stamp_q[w];
        old_way   = WayW'(w);
      end
    end
    if (hit) begin
      way_sel = hit_way;
    end else if (any_free) begin
      way_sel = free_way;
    end else begin
      way_sel = old_way;
    end
  end

  // Fetch window: one block or what the file still holds.
  logic [PosW-1:0]   faddr;
  logic [PosW-1:0]   fdiff;
  logic [SegW-1:0]   fbytes;

  assign faddr  = {tag, {OffW{1'b0}}};
  assign fdiff  = file_len_q - faddr;
  assign fbytes = (fdiff > PosW'(BlockBytes)) ? SegW'(BlockBytes) : fdiff[SegW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
    end else if (file_length_we_i) begin
      file_len_q <= file_length_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q   <= position_i;
      rem_q   <= len_sat;
      total_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.check) begin
      // After this clip the read ends at or before the file end; the segments
      // still use the file length for the fetch window.
      if (clip) rem_q <= LenW'(file_len_q - pos_q);
    end else if (cmd_i.seg) begin
      pos_q   <= pos_q + PosW'(seg);
      rem_q   <= rem_next;
      total_q <= total_q + LenW'(seg);
      cnt_q   <= cnt_q + CntW'(1);
    end
  end

  // Way table: valid bits and the stamp counter are reset, tags and stamps
  // are only looked at once their valid bit has been set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < Ways; w++) way_valid_q[w] <= 1'b0;
      next_stamp_q <= '0;
    end else if (cmd_i.inval) begin
      for (int w = 0; w < Ways; w++) way_valid_q[w] <= 1'b0;
    end else if (cmd_i.seg && !hit) begin
      way_valid_q[way_sel] <= 1'b1;
      next_stamp_q         <= next_stamp_q + StampW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg && !hit) begin
      way_tag_q[way_sel]   <= tag;
      way_stamp_q[way_sel] <= next_stamp_q;
    end
  end

  // Result beat registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.check && err) || cmd_i.seg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && err) begin
      way_q       <= '0;
      off_q       <= '0;
      seg_q       <= '0;
      hit_q       <= 1'b0;
      faddr_q     <= '0;
      fbytes_q    <= '0;
      err_q       <= 1'b1;
      total_out_q <= '0;
      last_q      <= 1'b1;
    end else if (cmd_i.seg) begin
      way_q       <= way_sel;
      off_q       <= off;
      seg_q       <= seg;
      hit_q       <= hit;
      faddr_q     <= hit ? '0 : faddr;
      fbytes_q    <= hit ? '0 : fbytes;
      err_q       <= 1'b0;
      total_out_q <= total_q + LenW'(seg);
      last_q      <= last;
    end
  end

  assign valid_o         = valid_q;
  assign way_o           = way_q;
  assign block_offset_o  = off_q;
  assign segment_bytes_o = seg_q;
  assign hit_o           = hit_q;
  assign fetch_needed_o  = !hit_q && !err_q;
  assign fetch_address_o = faddr_q;
  assign fetch_bytes_o   = fbytes_q;
  assign error_o         = err_q;
  assign total_bytes_o   = total_out_q;
  assign last_o          = last_q;

  // A reported segment always moves at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !err_q |-> seg_q != '0)
    else $error("empty segment reported");

  // A miss always fetches a nonempty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !err_q && !hit_q |-> fbytes_q != '0)
    else $error("miss with empty fetch");

  // The running count never exceeds the largest request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> total_out_q <= LenW'(MaxReqBytes))
    else $error("byte count overflow");

  // A miss marks its way valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seg && !hit |=> way_valid_q[$past(way_sel)])
    else $error("loaded way not valid");

endmodule

`default_nettype wire

// ----- hdl/block_read_cache_tag_controller_core.sv -----
// ----------------------------------------------------------------------------
// Block read cache tag controller
// Splits read requests into block segments and tracks which of the fully
// associative ways holds each block, with first-in first-out replacement.
// ----------------------------------------------------------------------------
//  Channel   | Handshake              | Payload
//  ----------+------------------------+---------------------------------------
//  command   | start / busy           | mode_i, position_i, length_i
//  config    | file_length_we_i       | file_length_i
//  result    | valid_o (one cycle)    | way_o ... last_o
//
// An invalidate command gives no beat. A read is range checked in the check
// state after the accepting edge, then reported segment by segment (up to
// nine), with a single tag lookup per segment and a way update on each miss;
// a rejected read gives its error beat after the check state. busy falls in
// the cycle that shows the final beat. Reset clears the valid bits, the stamp
// counter and the file length. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module block_read_cache_tag_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode_i,
  input  wire logic [brctc_pkg::PosW-1:0]    position_i,
  input  wire logic [brctc_pkg::LenW-1:0]    length_i,
  input  wire logic                          file_length_we_i,
  input  wire logic [brctc_pkg::PosW-1:0]    file_length_i,
  output logic                               valid_o,
  output logic [brctc_pkg::WayW-1:0]         way_o,
  output logic [brctc_pkg::OffW-1:0]         block_offset_o,
  output logic [brctc_pkg::SegW-1:0]         segment_bytes_o,
  output logic                               hit_o,
  output logic                               fetch_needed_o,
  output logic [brctc_pkg::PosW-1:0]         fetch_address_o,
  output logic [brctc_pkg::SegW-1:0]         fetch_bytes_o,
  output logic                               error_o,
  output logic [brctc_pkg::LenW-1:0]         total_bytes_o,
  output logic                               last_o
);
  import brctc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  brctc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  brctc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .file_length_we_i (file_length_we_i),
    .file_length_i    (file_length_i),
    .position_i       (position_i),
    .length_i         (length_i),
    .valid_o          (valid_o),
    .way_o            (way_o),
    .block_offset_o   (block_offset_o),
    .segment_bytes_o  (segment_bytes_o),
    .hit_o            (hit_o),
    .fetch_needed_o   (fetch_needed_o),
    .fetch_address_o  (fetch_address_o),
    .fetch_bytes_o    (fetch_bytes_o),
    .error_o          (error_o),
    .total_bytes_o    (total_bytes_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
